### design/track_switch_mode_controller_defines.svh
// Assertion macros used by the track switch mode controller design file.
`ifndef TRACK_SWITCH_MODE_CONTROLLER_DEFINES_SVH
`define TRACK_SWITCH_MODE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TSMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("track switch controller check failed");
// Next-cycle implication, checked outside reset.
`define TSMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("track switch controller check failed");
`else
`define TSMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/tsmc_pkg.sv
// Package with the codes, field widths and reset values of the track switch controller.
package tsmc_pkg;

  // Field widths.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned PosW      = 2;
  localparam int unsigned DirW      = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned PortW     = 1;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned PwmW      = 4;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 8;

  // Actions carried on the input tuser.
  localparam logic [ActionW-1:0] ACT_DETECT = 2'd0;
  localparam logic [ActionW-1:0] ACT_REMOTE = 2'd1;
  localparam logic [ActionW-1:0] ACT_BUTTON = 2'd2;

  // Train positions.
  localparam logic [PosW-1:0] POS_NONE  = 2'd0;
  localparam logic [PosW-1:0] POS_ENTER = 2'd1;

  // Train directions.
  localparam logic [DirW-1:0] DIR_NONE    = 2'd0;
  localparam logic [DirW-1:0] DIR_FORK    = 2'd1;
  localparam logic [DirW-1:0] DIR_MERGE   = 2'd2;
  localparam logic [DirW-1:0] DIR_INVALID = 2'd3;

  // Modes.
  localparam logic [ModeW-1:0] MODE_MANUAL    = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALTERNATE = 2'd1;
  localparam logic [ModeW-1:0] MODE_REDIRECT  = 2'd2;
  localparam logic [ModeW-1:0] MODE_LOOP      = 2'd3;

  // Detection codes.
  localparam logic [CodeW-1:0] CODE_NONE       = 3'd0;
  localparam logic [CodeW-1:0] CODE_MERGE_BASE = 3'd3;
  localparam logic [CodeW-1:0] CODE_NONE_SENT  = 3'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PORT      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [PortW-1:0] PORT_RESET      = 1'b1;
  localparam logic [ChanW-1:0] CHANNEL_RESET   = 3'd1;
  localparam logic [ThrW-1:0]  THRESHOLD_RESET = 16'd5000;

  // Remote request pwm value that means float.
  localparam logic [PwmW-1:0] PWM_FLOAT = 4'd0;

endpackage

### design/track_switch_mode_controller.sv
// Track switch mode controller: turns sensor and toggle words into switch commands.
//
// Usage: each input word on in_* carries one event, selected by in_tuser (detection,
// remote mode toggle or local button toggle). Every accepted word yields exactly one
// result word on out_*, holding the detection broadcast, a route toggle command, a
// mode broadcast flag and the current mode.
// Timing: the result appears in the cycle after the input word is accepted, held in a
// single output register. Throughput: one word per cycle while the receiver takes each
// result; the event decode, the elapsed-time subtract and the threshold compare all sit
// between the input port and the output register.
// Stalls: in_tready stays high while the output register is empty or is being emptied
// in the same cycle, so a stalled receiver holds the result and blocks new input only
// until that word is taken.
// Configuration: cfg_we writes the register chosen by cfg_index (0 port, 1 channel,
// 2 redirect threshold in ms) at the clock edge; write only while the block is idle.
// Reset: rst_n low, synchronous, returns to manual mode, forgets the last detection
// code, clears the redirect flags and exit time, and restores configuration defaults.
`include "track_switch_mode_controller_defines.svh"

module track_switch_mode_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields, low bit up: position[1:0], direction[3:2], now_ms[35:4], req_port[36],
  // req_channel[39:37], req_pwm[43:40], zero fill[47:44].
  input  logic [tsmc_pkg::InDataW-1:0]  in_tdata,
  // Fields: action[1:0].
  input  logic [tsmc_pkg::ActionW-1:0]  in_tuser,
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields, low bit up: send_detection[0], detection_code[3:1], toggle_track[4],
  // send_mode[5], mode_now[7:6].
  output logic [tsmc_pkg::OutDataW-1:0] out_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [tsmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tsmc_pkg::ThrW-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [tsmc_pkg::PortW-1:0] ctl_port_r;
  logic [tsmc_pkg::ChanW-1:0] ctl_chan_r;
  logic [tsmc_pkg::ThrW-1:0]  threshold_r;

  // Controller state.
  logic [tsmc_pkg::ModeW-1:0] mode_r, mode_nxt;
  logic [tsmc_pkg::CodeW-1:0] last_code_r, last_code_nxt;
  logic                       redirecting_r, redirecting_nxt;
  logic                       redirected_r, redirected_nxt;
  logic [tsmc_pkg::TimeW-1:0] last_exit_r, last_exit_nxt;

  // Output register.
  logic                          out_valid_r;
  logic [tsmc_pkg::OutDataW-1:0] out_data_r, out_data_nxt;

  // Unpacked input fields.
  logic [tsmc_pkg::ActionW-1:0] action;
  logic [tsmc_pkg::PosW-1:0]    position;
  logic [tsmc_pkg::DirW-1:0]    direction;
  logic [tsmc_pkg::TimeW-1:0]   now_ms;
  logic [tsmc_pkg::PortW-1:0]   req_port;
  logic [tsmc_pkg::ChanW-1:0]   req_channel;
  logic [tsmc_pkg::PwmW-1:0]    req_pwm;

  // Per-word decode.
  logic                       in_fire;
  logic [tsmc_pkg::CodeW-1:0] code;
  logic [tsmc_pkg::TimeW-1:0] elapsed;
  logic                       in_window;
  logic                       send_det;
  logic [tsmc_pkg::CodeW-1:0] code_out;
  logic                       toggle;
  logic                       send_mode;

  assign action      = in_tuser;
  assign position    = in_tdata[1:0];
  assign direction   = in_tdata[3:2];
  assign now_ms      = in_tdata[35:4];
  assign req_port    = in_tdata[36];
  assign req_channel = in_tdata[39:37];
  assign req_pwm     = in_tdata[43:40];

  // The output register can take a new word when empty or when it drains this cycle.
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Detection code and redirect window.
  always_comb begin
    if (position == tsmc_pkg::POS_NONE || direction == tsmc_pkg::DIR_NONE) begin
      code = tsmc_pkg::CODE_NONE;
    end else if (direction == tsmc_pkg::DIR_MERGE) begin
      code = {1'b0, position} + tsmc_pkg::CODE_MERGE_BASE;
    end else begin
      code = {1'b0, position};
    end
  end

  assign elapsed   = now_ms - last_exit_r;
  assign in_window = elapsed < {{(tsmc_pkg::TimeW - tsmc_pkg::ThrW){1'b0}}, threshold_r};

  // Event handling: next state and result fields.
  always_comb begin
    mode_nxt        = mode_r;
    last_code_nxt   = last_code_r;
    redirecting_nxt = redirecting_r;
    redirected_nxt  = redirected_r;
    last_exit_nxt   = last_exit_r;
    send_det        = 1'b0;
    code_out        = tsmc_pkg::CODE_NONE;
    toggle          = 1'b0;
    send_mode       = 1'b0;
    case (action)
      tsmc_pkg::ACT_DETECT: begin
        if (direction != tsmc_pkg::DIR_INVALID) begin
          if (code != last_code_r) begin
            send_det      = 1'b1;
            code_out      = code;
            last_code_nxt = code;
          end
          if (direction == tsmc_pkg::DIR_FORK) begin
            if (mode_r == tsmc_pkg::MODE_ALTERNATE) begin
              toggle = (position == tsmc_pkg::POS_NONE);
            end else if (mode_r == tsmc_pkg::MODE_REDIRECT ||
                         mode_r == tsmc_pkg::MODE_LOOP) begin
              if (!redirecting_r && !redirected_r &&
                  position == tsmc_pkg::POS_ENTER && in_window) begin
                toggle          = 1'b1;
                redirecting_nxt = 1'b1;
              end else if (position == tsmc_pkg::POS_NONE) begin
                // Clean exit: restore the route if this train was redirected.
                last_exit_nxt = now_ms;
                if (redirecting_r) begin
                  redirecting_nxt = 1'b0;
                  redirected_nxt  = (mode_r == tsmc_pkg::MODE_LOOP);
                  toggle          = 1'b1;
                end else begin
                  redirected_nxt = 1'b0;
                end
              end
            end
          end
        end
      end
      tsmc_pkg::ACT_REMOTE: begin
        if (req_port == ctl_port_r && req_channel == ctl_chan_r &&
            req_pwm == tsmc_pkg::PWM_FLOAT) begin
          mode_nxt  = mode_r + 2'd1;
          send_mode = 1'b1;
        end
      end
      tsmc_pkg::ACT_BUTTON: begin
        mode_nxt  = mode_r + 2'd1;
        send_mode = 1'b1;
      end
      default: begin
        // Unused action: no state change, empty result.
      end
    endcase
    out_data_nxt = {mode_nxt, send_mode, toggle, code_out, send_det};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_port_r  <= tsmc_pkg::PORT_RESET;
      ctl_chan_r  <= tsmc_pkg::CHANNEL_RESET;
      threshold_r <= tsmc_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tsmc_pkg::CFG_PORT:      ctl_port_r  <= cfg_wdata[tsmc_pkg::PortW-1:0];
        tsmc_pkg::CFG_CHANNEL:   ctl_chan_r  <= cfg_wdata[tsmc_pkg::ChanW-1:0];
        tsmc_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Controller state, updated once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= tsmc_pkg::MODE_MANUAL;
      last_code_r   <= tsmc_pkg::CODE_NONE_SENT;
      redirecting_r <= 1'b0;
      redirected_r  <= 1'b0;
      last_exit_r   <= '0;
    end else if (in_fire) begin
      mode_r        <= mode_nxt;
      last_code_r   <= last_code_nxt;
      redirecting_r <= redirecting_nxt;
      redirected_r  <= redirected_nxt;
      last_exit_r   <= last_exit_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A train is never both being redirected and marked as already redirected.
  `TSMC_ASSERT_IMP(a_flags_exclusive, clk, rst_n, 1'b1, !(redirecting_r && redirected_r))
  // A detection code is only shown when it is broadcast.
  `TSMC_ASSERT_IMP(a_code_needs_send, clk, rst_n, out_valid_r && !out_data_r[0],
    out_data_r[3:1] == tsmc_pkg::CODE_NONE)
  // A mode change and a route change never come from the same word.
  `TSMC_ASSERT_IMP(a_toggle_or_mode, clk, rst_n, out_valid_r, !(out_data_r[4] && out_data_r[5]))
  // A broadcast mode change advances the mode by one step.
  `TSMC_ASSERT_NXT(a_mode_step, clk, rst_n, in_fire && send_mode,
    mode_r == $past(mode_r) + 2'd1)
  // The reported mode matches the mode register after the word is taken.
  `TSMC_ASSERT_NXT(a_mode_report, clk, rst_n, in_fire, out_data_r[7:6] == mode_r)

endmodule
